@@ hw/rtl/uart_tx_frame_queue_top_macros.svh @@
// ----------------------------------------------------------------------------
// uart_tx_frame_queue_top_macros.svh
// assertion macros for the frame queue checker
// ----------------------------------------------------------------------------
`ifndef UART_TX_FRAME_QUEUE_TOP_MACROS_SVH
`define UART_TX_FRAME_QUEUE_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off while in reset
`define UTFQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define UTFQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/utfq_pkg.sv @@
// ----------------------------------------------------------------------------
// utfq_pkg
// shared types and constants of the uart transmit frame queue
// ----------------------------------------------------------------------------
`default_nettype none

package utfq_pkg;

	// default geometry of the ring
	localparam int QUEUE_SLOTS_DEF = 8;
	localparam int FRAME_BYTES_DEF = 64;

	// payload widths
	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;

	// request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 2'd0,
		CMD_TXDONE  = 2'd1,
		CMD_SERVICE = 2'd2
	} cmd_t;

	// push outcome reported with each result
	typedef enum logic [STATUS_W-1:0] {
		PUSH_NONE   = 2'd0,
		PUSH_ACCEPT = 2'd1,
		PUSH_REJECT = 2'd2,
		PUSH_DROP   = 2'd3
	} push_status_t;

	// frame store access strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/utfq_in_if.sv @@
// ----------------------------------------------------------------------------
// utfq_in_if
// request channel into the frame queue: command, byte and last marker
// ----------------------------------------------------------------------------
`default_nettype none

interface utfq_in_if
	import utfq_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] frame_byte;
	logic              last_byte;

	modport source (output valid, output cmd, output frame_byte, output last_byte,
		input ready);
	modport sink (input valid, input cmd, input frame_byte, input last_byte,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/utfq_out_if.sv @@
// ----------------------------------------------------------------------------
// utfq_out_if
// result channel out of the frame queue: transmit byte, push status, busy
// ----------------------------------------------------------------------------
`default_nettype none

interface utfq_out_if
	import utfq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                tx_valid;
	logic [BYTE_W-1:0]   tx_byte;
	logic [STATUS_W-1:0] push_status;
	logic                busy_res;

	modport source (output valid, output tx_valid, output tx_byte, output push_status,
		output busy_res, input ready);
	modport sink (input valid, input tx_valid, input tx_byte, input push_status,
		input busy_res, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/utfq_store.sv @@
// ----------------------------------------------------------------------------
// utfq_store
// frame byte memory: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module utfq_store
	import utfq_pkg::*;
#(
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  store_ctl_t        ctl,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [BYTE_W-1:0] rd_data
);
	localparam int DEPTH = 2 ** ADDR_W;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held until the next read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= mem[raddr];
		end
	end

	assign rd_data = rd_q;
endmodule

`default_nettype wire

@@ hw/rtl/uart_tx_frame_queue_top.sv @@
// ----------------------------------------------------------------------------
// uart_tx_frame_queue_top
// ring of frame slots feeding a byte-wide uart transmitter, interrupt mode
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result side keeps taking,
// and returns exactly one result per request, in order. A request is held in
// the input register and its result is loaded into the output register once
// that register frees. The transmitted byte comes from the frame store's
// registered read port, read on the same edge that loads the result. The
// frame store is not cleared after reset and needs no clearing pass: a byte
// is only ever sent after it has been written.
`default_nettype none

module uart_tx_frame_queue_top
	import utfq_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF,
	parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	utfq_in_if.sink    item,
	utfq_out_if.source result
);
	localparam int SW = $clog2(QUEUE_SLOTS);
	localparam int PW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int LW = $clog2(FRAME_BYTES + 1);
	localparam int AW = SW + PW;
	localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_SLOTS - 1);
	localparam logic [LW-1:0] FRAME_MAX = LW'(FRAME_BYTES);

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	// input stage
	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// result stage
	logic         valid_s2;
	logic         txv_s2;
	push_status_t status_s2;
	logic         busy_s2;

	// queue state
	logic [SW-1:0] head_q, tail_q;
	logic [LW-1:0] send_q, fill_q;
	logic          busy_q, rej_q;
	logic [LW-1:0] len_q [QUEUE_SLOTS];

	// next state
	logic [SW-1:0] head_d, tail_d, head_nx, tail_nx;
	logic [LW-1:0] send_d, fill_d, fill_inc, head_len;
	logic          busy_d, rej_d, txv_d;
	logic [LW-1:0] len_d [QUEUE_SLOTS];
	push_status_t  status_d;
	store_ctl_t    ctl_d, ctl;
	logic [AW-1:0] waddr, raddr;
	logic [BYTE_W-1:0] rd_data;

	logic advance;

	// handshake: the input register moves on whenever the result register frees
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	// request decode and queue update
	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		send_d   = send_q;
		fill_d   = fill_q;
		busy_d   = busy_q;
		rej_d    = rej_q;
		len_d    = len_q;
		txv_d    = 1'b0;
		status_d = PUSH_NONE;
		ctl_d    = '0;
		head_len = len_q[head_q];
		head_nx  = next_slot(head_q);
		tail_nx  = next_slot(tail_q);
		fill_inc = fill_q;
		waddr    = {tail_q, fill_q[PW-1:0]};
		raddr    = {head_q, send_q[PW-1:0]};
		case (cmd_s1)
			CMD_PUSH: begin
				if (fill_q == '0 && !rej_q && tail_nx == head_q) begin
					// ring full at frame start
					status_d = PUSH_REJECT;
					rej_d    = !last_s1;
				end else if (rej_q) begin
					status_d = PUSH_REJECT;
					if (last_s1) begin
						rej_d = 1'b0;
					end
				end else begin
					if (fill_q < FRAME_MAX) begin
						ctl_d.wr_en = 1'b1;
						fill_inc    = fill_q + 1'b1;
						status_d    = PUSH_ACCEPT;
					end else begin
						status_d = PUSH_DROP;
					end
					fill_d = fill_inc;
					// commit the frame on its last byte
					if (last_s1) begin
						len_d[tail_q]  = fill_inc;
						len_d[tail_nx] = '0;
						tail_d         = tail_nx;
						fill_d         = '0;
					end
				end
			end
			CMD_SERVICE: begin
				if (head_q != tail_q && !busy_q && send_q < head_len) begin
					txv_d       = 1'b1;
					ctl_d.rd_en = 1'b1;
					send_d      = send_q + 1'b1;
					busy_d      = 1'b1;
				end
			end
			CMD_TXDONE: begin
				if (busy_q) begin
					if (send_q < head_len) begin
						txv_d       = 1'b1;
						ctl_d.rd_en = 1'b1;
						send_d      = send_q + 1'b1;
					end else begin
						// frame done: free the slot and move on
						len_d[head_q] = '0;
						head_d        = head_nx;
						send_d        = '0;
						if (head_nx != tail_q) begin
							txv_d       = 1'b1;
							ctl_d.rd_en = 1'b1;
							raddr       = {head_nx, PW'(0)};
							send_d      = LW'(1);
						end else begin
							busy_d = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.wr_en = advance && ctl_d.wr_en;
	assign ctl.rd_en = advance && ctl_d.rd_en;

	utfq_store #(
		.ADDR_W(AW)
	) u_store (
		.clk    (clk),
		.ctl    (ctl),
		.waddr  (waddr),
		.wdata  (byte_s1),
		.raddr  (raddr),
		.rd_data(rd_data)
	);

	// stage valids and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			send_q   <= '0;
			fill_q   <= '0;
			busy_q   <= 1'b0;
			rej_q    <= 1'b0;
			for (int i = 0; i < QUEUE_SLOTS; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance) begin
				head_q <= head_d;
				tail_q <= tail_d;
				send_q <= send_d;
				fill_q <= fill_d;
				busy_q <= busy_d;
				rej_q  <= rej_d;
				len_q  <= len_d;
			end
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_s1  <= cmd_t'(item.cmd);
			byte_s1 <= item.frame_byte;
			last_s1 <= item.last_byte;
		end
	end

	// result payload capture
	always_ff @(posedge clk) begin
		if (advance) begin
			txv_s2    <= txv_d;
			status_s2 <= status_d;
			busy_s2   <= busy_d;
		end
	end

	// result drive
	assign result.valid       = valid_s2;
	assign result.tx_valid    = txv_s2;
	assign result.tx_byte     = txv_s2 ? rd_data : '0;
	assign result.push_status = status_s2;
	assign result.busy_res    = busy_s2;
endmodule

`default_nettype wire

@@ hw/rtl/utfq_checker.sv @@
// ----------------------------------------------------------------------------
// utfq_checker
// port-level assertions on the frame queue result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_tx_frame_queue_top_macros.svh"

module utfq_checker
	import utfq_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic                tx_valid,
	input wire logic [BYTE_W-1:0]   tx_byte,
	input wire logic [STATUS_W-1:0] push_status,
	input wire logic                busy_res
);
	// no byte handed over means a zero byte
	`UTFQ_ASSERT_IMP(a_idle_byte_zero, out_valid && !tx_valid, tx_byte == '0, "tx_byte not zero while tx_valid is low")

	// a push request never hands a byte to the transmitter
	`UTFQ_ASSERT_IMP(a_push_no_tx, out_valid && push_status != PUSH_NONE, !tx_valid, "byte sent on a push request")

	// a handed byte leaves the transmitter busy
	`UTFQ_ASSERT_IMP(a_tx_busy, out_valid && tx_valid, busy_res, "byte sent while busy flag low")

	// a stalled result holds
	`UTFQ_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(push_status) && $stable(busy_res), "stalled result changed")
endmodule

bind uart_tx_frame_queue_top utfq_checker u_utfq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.tx_valid   (result.tx_valid),
	.tx_byte    (result.tx_byte),
	.push_status(result.push_status),
	.busy_res   (result.busy_res)
);

`default_nettype wire

@@ verif/tb_uart_tx_frame_queue_top.sv @@
// ----------------------------------------------------------------------------
// tb_uart_tx_frame_queue_top
// self-checking bench for the uart transmit frame queue
// ----------------------------------------------------------------------------
// Requests are queued up front and handed out by a falling-edge driver with
// random gaps. Every request taken by the block runs through a request model of
// the slot ring, and the predicted result waits in order until the monitor
// sees the block's result. The result side stalls at random and twice holds
// off for a long stretch so the block backs up into the request side. The
// directed opening fills the ring to the brim, rejects a frame and drains it
// again. The random part alternates fill-heavy and drain-heavy spans of
// frames, with a few frames past the slot capacity.
`default_nettype none

module tb_uart_tx_frame_queue_top;
	import utfq_pkg::*;

	localparam int SLOTS = QUEUE_SLOTS_DEF;
	localparam int BYTES = FRAME_BYTES_DEF;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int LEN_W = $clog2(BYTES) + 1;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] data;
		logic              last;
	} request_t;

	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		push_status_t      push_status;
		logic              busy_res;
	} tx_result_t;

	logic clk;
	logic arst_n;

	utfq_in_if  req_if ();
	utfq_out_if res_if ();

	uart_tx_frame_queue_top #(
		.QUEUE_SLOTS(SLOTS),
		.FRAME_BYTES(BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(req_if),
		.result(res_if)
	);

	// requests still to be offered and results still owed by the block
	request_t   request_q [$];
	tx_result_t tx_results [$];
	request_t   next_req;
	int         request_total;
	int         useful_cnt;
	int         accepted_cnt = 0;
	int         fail_cnt = 0;
	int         cycle_cnt = 0;
	int         send_gap = 0;
	int         stall_left = 0;
	int         hold_left = 0;
	int         holds_done = 0;
	logic       in_taken = 1'b0;
	logic       quiet_span;

	// shadow copy of the slot ring
	logic [BYTE_W-1:0] ring_bytes [SLOTS*BYTES];
	logic [LEN_W-1:0]  ring_len [SLOTS] = '{default: '0};
	logic [SLOT_W-1:0] head_idx = '0;
	logic [SLOT_W-1:0] tail_idx = '0;
	logic [LEN_W-1:0]  send_idx = '0;
	logic [LEN_W-1:0]  fill_cnt = '0;
	logic              tx_active = 1'b0;
	logic              discarding = 1'b0;

	// stretches with no random gaps or stalls on either side
	assign quiet_span = ((cycle_cnt / 2500) % 4) == 3;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return SLOT_W'((int'(s) + 1) % SLOTS);
	endfunction

	// hand over the byte at the send position of the head frame
	function automatic logic [BYTE_W-1:0] pull_tx_byte();
		logic [BYTE_W-1:0] b;
		b = '0;
		if (send_idx < BYTES)
			b = ring_bytes[int'(head_idx)*BYTES + int'(send_idx)];
		send_idx = send_idx + 1'b1;
		return b;
	endfunction

	// advance the shadow ring by one request and return the expected result
	function automatic tx_result_t frame_queue_step(input logic [CMD_W-1:0] cmd,
			input logic [BYTE_W-1:0] data, input logic last);
		tx_result_t r;
		r.tx_valid = 1'b0;
		r.tx_byte = '0;
		r.push_status = PUSH_NONE;
		case (cmd)
			CMD_PUSH: begin
				if (fill_cnt == 0 && !discarding && next_slot(tail_idx) == head_idx) begin
					// ring full at the first byte: drop the whole frame
					r.push_status = PUSH_REJECT;
					discarding = !last;
				end else if (discarding) begin
					r.push_status = PUSH_REJECT;
					if (last)
						discarding = 1'b0;
				end else begin
					if (fill_cnt < BYTES) begin
						ring_bytes[int'(tail_idx)*BYTES + int'(fill_cnt)] = data;
						fill_cnt = fill_cnt + 1'b1;
						r.push_status = PUSH_ACCEPT;
					end else begin
						r.push_status = PUSH_DROP;
					end
					// commit the frame, truncated if it ran long
					if (last) begin
						ring_len[tail_idx] = fill_cnt;
						tail_idx = next_slot(tail_idx);
						ring_len[tail_idx] = '0;
						fill_cnt = '0;
					end
				end
			end
			CMD_SERVICE: begin
				if (head_idx != tail_idx && !tx_active && send_idx < ring_len[head_idx]) begin
					r.tx_byte = pull_tx_byte();
					r.tx_valid = 1'b1;
					tx_active = 1'b1;
				end
			end
			CMD_TXDONE: begin
				if (tx_active) begin
					if (send_idx < ring_len[head_idx]) begin
						r.tx_byte = pull_tx_byte();
						r.tx_valid = 1'b1;
					end else begin
						// frame done: free the slot and move on
						ring_len[head_idx] = '0;
						head_idx = next_slot(head_idx);
						send_idx = '0;
						if (head_idx != tail_idx) begin
							r.tx_byte = pull_tx_byte();
							r.tx_valid = 1'b1;
						end else begin
							tx_active = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.busy_res = tx_active;
		return r;
	endfunction

	function automatic int idle_len(input logic quiet);
		int roll;
		roll = $urandom_range(99);
		if (quiet || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
			input logic last);
		request_q.push_back('{cmd, data, last});
		if (cmd != CMD_RESERVED)
			useful_cnt++;
	endtask

	// stimulus, reset and end of run
	initial begin
		int roll;
		int len;
		logic fill_phase;
		arst_n = 1'b0;
		useful_cnt = 0;

		// idle commands on an empty ring, unused code
		add_request(CMD_SERVICE, 8'h00, 1'b0);
		add_request(CMD_TXDONE, 8'hFF, 1'b1);
		add_request(CMD_RESERVED, 8'hFF, 1'b1);
		// seven one-byte frames fill the ring
		add_request(CMD_PUSH, 8'h00, 1'b1);
		add_request(CMD_PUSH, 8'hFF, 1'b1);
		add_request(CMD_PUSH, 8'h01, 1'b1);
		add_request(CMD_PUSH, 8'h80, 1'b1);
		add_request(CMD_PUSH, 8'h7F, 1'b1);
		add_request(CMD_PUSH, 8'hAA, 1'b1);
		add_request(CMD_PUSH, 8'h55, 1'b1);
		// two-byte frame on a full ring is rejected
		add_request(CMD_PUSH, 8'hC3, 1'b0);
		add_request(CMD_PUSH, 8'h3C, 1'b1);
		// start sending, poll while busy, retire the first frame
		add_request(CMD_SERVICE, 8'hFF, 1'b1);
		add_request(CMD_SERVICE, 8'h00, 1'b0);
		add_request(CMD_TXDONE, 8'h00, 1'b0);
		add_request(CMD_PUSH, 8'h33, 1'b1);
		add_request(CMD_RESERVED, 8'h00, 1'b0);
		// drain to idle, then one completion while idle
		repeat (8) add_request(CMD_TXDONE, 8'h00, 1'b0);

		// random frames, alternating fill-heavy and drain-heavy spans
		while (useful_cnt < RANDOM_ITEMS + 25) begin
			fill_phase = ((useful_cnt / 160) % 2) == 0;
			roll = $urandom_range(99);
			if (roll < (fill_phase ? 50 : 25)) begin
				roll = $urandom_range(99);
				if (roll < 80)
					len = $urandom_range(6, 1);
				else if (roll < 94)
					len = $urandom_range(63, 7);
				else
					len = $urandom_range(70, 64);
				for (int i = 0; i < len; i++) begin
					add_request(CMD_PUSH, BYTE_W'($urandom_range(255)), i == len - 1);
					// events may land in the middle of a frame
					if ($urandom_range(99) < 15)
						add_request($urandom_range(1) ? CMD_TXDONE : CMD_SERVICE,
							BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
				end
			end else if (roll < 85) begin
				repeat ($urandom_range(fill_phase ? 3 : 12, 1))
					add_request(CMD_TXDONE, BYTE_W'($urandom_range(255)),
						1'($urandom_range(1)));
			end else if (roll < 95) begin
				add_request(CMD_SERVICE, BYTE_W'($urandom_range(255)),
					1'($urandom_range(1)));
			end else if ($urandom_range(1)) begin
				add_request(CMD_RESERVED, BYTE_W'($urandom_range(255)),
					1'($urandom_range(1)));
			end else begin
				// stray unterminated byte merges into the next frame
				add_request(CMD_PUSH, BYTE_W'($urandom_range(255)), 1'b0);
			end
		end
		request_total = request_q.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt < request_total)
			@(posedge clk);
		while (tx_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (!req_if.valid || in_taken) begin
			if (send_gap > 0) begin
				req_if.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (request_q.size() != 0) begin
				next_req = request_q.pop_front();
				req_if.valid <= 1'b1;
				req_if.cmd <= next_req.cmd;
				req_if.frame_byte <= next_req.data;
				req_if.last_byte <= next_req.last;
				send_gap <= idle_len(quiet_span);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// result side: random stalls plus long hold-offs that back the block up
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && accepted_cnt >= 600 * (holds_done + 1)) begin
			res_if.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else if (stall_left > 0) begin
			res_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			res_if.ready <= 1'b1;
			stall_left <= idle_len(quiet_span);
		end
	end

	// monitor: check results in order, then predict for the request taken
	always @(posedge clk) begin
		tx_result_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= req_if.valid && req_if.ready;
			if (res_if.valid && res_if.ready) begin
				if (tx_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_cnt++;
				end else begin
					want = tx_results.pop_front();
					if (res_if.tx_valid !== want.tx_valid) begin
						$error("tx_valid: expected %0d, got %0d", want.tx_valid, res_if.tx_valid);
						fail_cnt++;
					end
					if (res_if.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %h, got %h", want.tx_byte, res_if.tx_byte);
						fail_cnt++;
					end
					if (res_if.push_status !== want.push_status) begin
						$error("push_status: expected %0d, got %0d", want.push_status,
							res_if.push_status);
						fail_cnt++;
					end
					if (res_if.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0d, got %0d", want.busy_res, res_if.busy_res);
						fail_cnt++;
					end
				end
			end
			if (req_if.valid && req_if.ready) begin
				tx_results.push_back(frame_queue_step(req_if.cmd, req_if.frame_byte,
					req_if.last_byte));
				accepted_cnt++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/utfq_pkg.sv
hw/rtl/utfq_in_if.sv
hw/rtl/utfq_out_if.sv
hw/rtl/utfq_store.sv
hw/rtl/uart_tx_frame_queue_top.sv
hw/rtl/utfq_checker.sv
verif/tb_uart_tx_frame_queue_top.sv
